### rtl/assert_macros.svh
// Assertion macros used by the checker file lcas_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: property failed");

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");

`endif

### rtl/lcas_pkg.sv
// Types, constants and helper functions of the life automaton step unit.
package lcas_pkg;

  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 64;

  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int LIVE_W    = 13;
  localparam int GEN_W     = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IDX = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_IDX = 1'b1;
  localparam logic [CFG_W-1:0]     CFG_RESET    = 7'd64;

  localparam logic [LIVE_W-1:0] LIVE_SAT = 13'd8191;
  localparam logic [GEN_W-1:0]  GEN_MAX  = 16'hFFFF;

  // B3/S23 neighbor counts.
  localparam logic [3:0] BIRTH_CNT   = 4'd3;
  localparam logic [3:0] SURVIVE_CNT = 4'd2;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_SET     = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [5:0] row;
    logic [5:0] col;
  } in_item_t;

  typedef struct packed {
    logic              cell_alive;
    logic [LIVE_W-1:0] live_total;
    logic [GEN_W-1:0]  generation;
    logic              stable;
    logic              extinct;
  } out_item_t;

  function automatic logic [3:0] pop8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(v[i]);
    end
    return n;
  endfunction

endpackage

### rtl/life_cellular_automaton_step_unit.sv
// Top level of the life automaton step unit: row-serial grid sweep engine.
//
// Usage: an item (op, row, col) is taken on in_item at a clock edge where start
// is high and busy is low. Every item gives exactly one result beat on out_item,
// marked by out_strobe for a single cycle; the receiver must take it then.
// Configuration (rows and columns in use) is written through cfg_we, cfg_idx and
// cfg_wdata by the user only while the unit is idle (not enforced); there is no read-back.
// Flow: a clear goes straight to the finish state, from which its result is
// registered. Set, read and advance stream every row in use, one row per cycle,
// out of the grid memory through a three-row window, then drain the pipeline
// before the finish state registers their result. busy falls in the cycle in which
// the result is shown, so the next item may be taken then. The single read port of
// the grid memory, one row per cycle, paces the sweep.
// Reset: synchronous on rst_n low; the grid reads as all dead (per-row valid
// bits are cleared), counters and flags are zero, and 64 x 64 is in use.
module life_cellular_automaton_step_unit #(
  parameter int MAX_ROWS = lcas_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = lcas_pkg::MAX_COLS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  lcas_pkg::in_item_t                 in_item,
  output logic                               out_strobe,
  output lcas_pkg::out_item_t                out_item,
  input  logic                               cfg_we,
  input  logic [lcas_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [lcas_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int CFG_W   = lcas_pkg::CFG_W;
  localparam int LIVE_W  = lcas_pkg::LIVE_W;
  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int RCNT_W  = $clog2(MAX_ROWS + 1);
  localparam int RC_W    = (RCNT_W > CFG_W) ? RCNT_W : CFG_W;
  localparam int NBYTE   = (MAX_COLS + 7) / 8;
  localparam int PAD_W   = NBYTE * 8;
  localparam int BSUM_W  = $clog2(MAX_COLS + 1);
  localparam int ACC_W   = $clog2(MAX_ROWS * MAX_COLS + 1);
  localparam int SAT_W   = (ACC_W > LIVE_W) ? ACC_W : LIVE_W;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SWEEP  = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] cfg_rows_r, cfg_cols_r;
  logic [RC_W-1:0]  rows_ext, eff_rows;
  logic [CFG_W-1:0] eff_cols;
  logic [MAX_COLS-1:0] msk;

  lcas_pkg::in_item_t item_r;
  logic               inside_r;
  logic               accept;

  // Grid memory with per-row valid bits; an invalid row reads as all dead.
  logic [MAX_COLS-1:0] grid_mem [MAX_ROWS];
  logic [MAX_ROWS-1:0] row_vld_r;
  logic [MAX_COLS-1:0] mem_q_r;
  logic                vld_q_r;
  logic [ROW_W-1:0]    rd_addr;
  logic                wr_en;
  logic [ROW_W-1:0]    wr_addr;
  logic [MAX_COLS-1:0] wr_data;

  logic [RC_W-1:0]     rd_cnt_r;
  logic                s1_v_r, s1_pad_r;
  logic [RC_W-1:0]     s1_idx_r;
  logic [MAX_COLS-1:0] win0_r, win1_r, win2_r;
  logic                s2_v_r, s2_last_r;
  logic [ROW_W-1:0]    s2_row_r;
  logic                s3_v_r, s3_last_r;
  logic [MAX_COLS-1:0] cnt_row_r;
  logic [PAD_W-1:0]    cnt_pad;
  logic                s4_v_r, s4_last_r;
  logic [3:0]          bc_r [NBYTE];
  logic [BSUM_W-1:0]   row_sum;

  logic [MAX_COLS-1:0] wa, wb, wc;
  logic [MAX_COLS-1:0] wa_l, wa_r, wb_l, wb_r, wc_l, wc_r;
  logic [3:0]          nb [MAX_COLS];
  logic [MAX_COLS-1:0] fresh, new_row, set_bit, cell_sh;
  logic                is_adv, row_hit, set_hit, read_hit;

  logic                changed_r, cell_r;
  logic [ACC_W-1:0]    acc_r;
  logic [SAT_W-1:0]    acc_ext;
  logic [LIVE_W-1:0]   live_sat;
  logic [lcas_pkg::GEN_W-1:0] gen_r;
  logic                stable_r;

  logic                out_strobe_r;
  lcas_pkg::out_item_t out_item_r;

  // Register values out of range act as the nearest legal bound.
  always_comb begin
    rows_ext = RC_W'(cfg_rows_r);
    if (rows_ext == '0) begin
      eff_rows = RC_W'(1);
    end else if (rows_ext > RC_W'(MAX_ROWS)) begin
      eff_rows = RC_W'(MAX_ROWS);
    end else begin
      eff_rows = rows_ext;
    end
    if (cfg_cols_r == '0) begin
      eff_cols = CFG_W'(1);
    end else if (cfg_cols_r > CFG_W'(MAX_COLS)) begin
      eff_cols = CFG_W'(MAX_COLS);
    end else begin
      eff_cols = cfg_cols_r;
    end
    for (int j = 0; j < MAX_COLS; j++) begin
      msk[j] = (CFG_W'(j) < eff_cols);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_rows_r <= lcas_pkg::CFG_RESET;
      cfg_cols_r <= lcas_pkg::CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        lcas_pkg::CFG_ROWS_IDX: cfg_rows_r <= cfg_wdata;
        lcas_pkg::CFG_COLS_IDX: cfg_cols_r <= cfg_wdata;
      endcase
    end
  end

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (in_item.op == lcas_pkg::OP_CLEAR) ? S_FINISH : S_SWEEP;
        end
      end
      S_SWEEP: begin
        if (rd_cnt_r == eff_rows) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (s4_v_r && s4_last_r) state_nxt = S_FINISH;
      end
      S_FINISH: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Window center is row s2_row_r; outer rows are its neighbors.
  always_comb begin
    wa   = win0_r & msk;
    wb   = win1_r & msk;
    wc   = win2_r & msk;
    wa_l = wa << 1;
    wa_r = wa >> 1;
    wb_l = wb << 1;
    wb_r = wb >> 1;
    wc_l = wc << 1;
    wc_r = wc >> 1;
    for (int j = 0; j < MAX_COLS; j++) begin
      nb[j] = 4'(wa_l[j]) + 4'(wa[j]) + 4'(wa_r[j]) + 4'(wb_l[j]) + 4'(wb_r[j])
            + 4'(wc_l[j]) + 4'(wc[j]) + 4'(wc_r[j]);
      fresh[j] = msk[j] & ((nb[j] == lcas_pkg::BIRTH_CNT) ||
                           (wb[j] && (nb[j] == lcas_pkg::SURVIVE_CNT)));
    end
  end

  assign is_adv   = (item_r.op == lcas_pkg::OP_ADVANCE);
  assign row_hit  = inside_r && (RC_W'(s2_row_r) == RC_W'(item_r.row));
  assign set_hit  = row_hit && (item_r.op == lcas_pkg::OP_SET);
  assign read_hit = row_hit && (item_r.op == lcas_pkg::OP_READ);
  assign set_bit  = MAX_COLS'(1) << item_r.col;
  assign cell_sh  = wb >> item_r.col;
  assign new_row  = is_adv ? fresh : (set_hit ? (wb | set_bit) : wb);

  // Cells outside the columns in use keep their stored value on write-back.
  assign rd_addr = rd_cnt_r[ROW_W-1:0];
  assign wr_en   = s2_v_r && (is_adv || set_hit);
  assign wr_addr = s2_row_r;
  assign wr_data = (win1_r & ~msk) | new_row;

  always_ff @(posedge clk) begin
    if (wr_en) grid_mem[wr_addr] <= wr_data;
    mem_q_r <= grid_mem[rd_addr];
  end

  assign cnt_pad = PAD_W'(cnt_row_r);

  always_comb begin
    row_sum = '0;
    for (int i = 0; i < NBYTE; i++) begin
      row_sum = row_sum + BSUM_W'(bc_r[i]);
    end
  end

  assign acc_ext  = SAT_W'(acc_r);
  assign live_sat = (acc_ext > SAT_W'(lcas_pkg::LIVE_SAT)) ? lcas_pkg::LIVE_SAT
                                                           : acc_ext[LIVE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      s2_last_r    <= 1'b0;
      s3_v_r       <= 1'b0;
      s3_last_r    <= 1'b0;
      s4_v_r       <= 1'b0;
      s4_last_r    <= 1'b0;
      out_strobe_r <= 1'b0;
      row_vld_r    <= '0;
      acc_r        <= '0;
      gen_r        <= '0;
      stable_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      s1_v_r       <= (state_r == S_SWEEP);
      s2_v_r       <= s1_v_r && (s1_idx_r != '0);
      s2_last_r    <= s1_v_r && s1_pad_r;
      s3_v_r       <= s2_v_r;
      s3_last_r    <= s2_v_r && s2_last_r;
      s4_v_r       <= s3_v_r;
      s4_last_r    <= s3_v_r && s3_last_r;
      out_strobe_r <= (state_r == S_FINISH);
      if (wr_en) row_vld_r[wr_addr] <= 1'b1;
      if (s4_v_r) acc_r <= acc_r + ACC_W'(row_sum);
      if (s4_v_r && s4_last_r && is_adv) begin
        if (gen_r != lcas_pkg::GEN_MAX) gen_r <= gen_r + 1'b1;
        stable_r <= !changed_r;
      end
      if (accept) begin
        acc_r <= '0;
        if (in_item.op == lcas_pkg::OP_CLEAR) begin
          row_vld_r <= '0;
          gen_r     <= '0;
          stable_r  <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    vld_q_r  <= row_vld_r[rd_addr];
    s1_idx_r <= rd_cnt_r;
    s1_pad_r <= (rd_cnt_r == eff_rows);
    s2_row_r <= ROW_W'(s1_idx_r - RC_W'(1));
    if (state_r == S_SWEEP) rd_cnt_r <= rd_cnt_r + RC_W'(1);
    // The extra beat past the last row shifts in the dead row below the grid.
    if (s1_v_r) begin
      win0_r <= win1_r;
      win1_r <= win2_r;
      win2_r <= (s1_pad_r || !vld_q_r) ? '0 : mem_q_r;
    end
    if (s2_v_r) begin
      cnt_row_r <= new_row;
      if (is_adv && (fresh != wb)) changed_r <= 1'b1;
      if (read_hit) cell_r <= cell_sh[0];
    end
    if (s3_v_r) begin
      for (int i = 0; i < NBYTE; i++) begin
        bc_r[i] <= lcas_pkg::pop8(cnt_pad[i*8 +: 8]);
      end
    end
    if (state_r == S_FINISH) begin
      out_item_r.cell_alive <= cell_r;
      out_item_r.live_total <= live_sat;
      out_item_r.generation <= gen_r;
      out_item_r.stable     <= stable_r;
      out_item_r.extinct    <= (acc_r == '0);
    end
    if (accept) begin
      item_r    <= in_item;
      inside_r  <= (RC_W'(in_item.row) < eff_rows) && (CFG_W'(in_item.col) < eff_cols);
      rd_cnt_r  <= '0;
      win2_r    <= '0;
      changed_r <= 1'b0;
      cell_r    <= 1'b0;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

### rtl/lcas_checker.sv
// Port-level checker of the life automaton step unit, bound to the top level.
`include "assert_macros.svh"

module lcas_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_strobe,
  input lcas_pkg::out_item_t out_item
);

  // An accepted item always makes the unit busy in the next cycle.
  `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)

  // No result beat can follow its item in the very next cycle.
  `ASSERT_NEXT(a_no_early_result, clk, rst_n, start && !busy, !out_strobe)

  // A result is shown only once the unit has finished its item.
  `ASSERT_IMPLY(a_result_idle, clk, rst_n, out_strobe, !busy)

  // The extinct flag agrees with the reported live count.
  `ASSERT_IMPLY(a_extinct_count, clk, rst_n, out_strobe, out_item.extinct == (out_item.live_total == '0))

endmodule

bind life_cellular_automaton_step_unit lcas_checker u_lcas_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);

### dv/tb_top.sv
// Self-checking testbench for the life automaton step unit with a grid predictor.
`timescale 1ns / 1ps

module tb_top;

  localparam int HALF_PERIOD  = 6;
  localparam int ITEM_TARGET  = 1950;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 80;
  localparam int CFG_W        = lcas_pkg::CFG_W;
  localparam int LIVE_W       = lcas_pkg::LIVE_W;

  // Tracks the grid, counters and sizes, and holds the result beats still to come.
  class life_tracker;
    logic [63:0]                 cells [64];
    logic [CFG_W-1:0]            rows_reg;
    logic [CFG_W-1:0]            cols_reg;
    logic [lcas_pkg::GEN_W-1:0]  gen_ctr;
    logic                        stable_now;
    lcas_pkg::out_item_t         awaited[$];
    int                          errors;
    int                          beats;

    function void reset_state();
      foreach (cells[r]) cells[r] = '0;
      rows_reg   = lcas_pkg::CFG_RESET;
      cols_reg   = lcas_pkg::CFG_RESET;
      gen_ctr    = '0;
      stable_now = 1'b0;
      errors     = 0;
      beats      = 0;
    endfunction

    function void write_reg(logic [lcas_pkg::CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == lcas_pkg::CFG_ROWS_IDX) rows_reg = val;
      else if (idx == lcas_pkg::CFG_COLS_IDX) cols_reg = val;
    endfunction

    function int eff_rows();
      if (rows_reg == 0) return 1;
      if (rows_reg > lcas_pkg::MAX_ROWS_DEF) return lcas_pkg::MAX_ROWS_DEF;
      return int'(rows_reg);
    endfunction

    function int eff_cols();
      if (cols_reg == 0) return 1;
      if (cols_reg > lcas_pkg::MAX_COLS_DEF) return lcas_pkg::MAX_COLS_DEF;
      return int'(cols_reg);
    endfunction

    function logic [63:0] col_mask();
      if (eff_cols() >= 64) return '1;
      return (64'd1 << eff_cols()) - 64'd1;
    endfunction

    function bit alive_at(int r, int c);
      if (r < 0 || c < 0 || r >= eff_rows() || c >= eff_cols()) return 1'b0;
      return cells[r][c];
    endfunction

    function int live_cells();
      int n;
      n = 0;
      for (int r = 0; r < eff_rows(); r++) n += $countones(cells[r] & col_mask());
      return n;
    endfunction

    // Every new cell is worked out from the old generation; cells beyond the
    // area in use keep their value and never act as neighbors.
    function void advance();
      logic [63:0] nxt [64];
      logic [63:0] m;
      int          k;
      bit          changed;
      m = col_mask();
      changed = 1'b0;
      for (int r = 0; r < eff_rows(); r++) begin
        nxt[r] = cells[r] & ~m;
        for (int c = 0; c < eff_cols(); c++) begin
          k = 0;
          for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
              if ((dr != 0 || dc != 0) && alive_at(r + dr, c + dc)) k++;
            end
          end
          if (k == lcas_pkg::BIRTH_CNT ||
              (k == lcas_pkg::SURVIVE_CNT && alive_at(r, c))) nxt[r][c] = 1'b1;
        end
        if ((nxt[r] & m) != (cells[r] & m)) changed = 1'b1;
      end
      for (int r = 0; r < eff_rows(); r++) cells[r] = nxt[r];
      stable_now = !changed;
      if (gen_ctr != lcas_pkg::GEN_MAX) gen_ctr = gen_ctr + 1'b1;
    endfunction

    function void note_item(lcas_pkg::in_item_t it);
      lcas_pkg::out_item_t want;
      bit                  in_area;
      int                  n;
      want = '0;
      in_area = int'(it.row) < eff_rows() && int'(it.col) < eff_cols();
      unique case (it.op)
        lcas_pkg::OP_CLEAR: begin
          foreach (cells[r]) cells[r] = '0;
          gen_ctr    = '0;
          stable_now = 1'b0;
        end
        lcas_pkg::OP_SET: begin
          if (in_area) cells[it.row][it.col] = 1'b1;
        end
        lcas_pkg::OP_ADVANCE: begin
          advance();
        end
        default: begin
          if (in_area) want.cell_alive = cells[it.row][it.col];
        end
      endcase
      n = live_cells();
      want.live_total = (n > int'(lcas_pkg::LIVE_SAT)) ? lcas_pkg::LIVE_SAT : n[LIVE_W-1:0];
      want.generation = gen_ctr;
      want.stable     = stable_now;
      want.extinct    = (n == 0);
      awaited.push_back(want);
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH beat %0d: %s", beats, msg);
      errors++;
    endtask

    task check_result(lcas_pkg::out_item_t got);
      lcas_pkg::out_item_t want;
      beats++;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing awaited, got %h", got));
        return;
      end
      want = awaited.pop_front();
      if (got.cell_alive !== want.cell_alive)
        report_mismatch($sformatf("cell_alive %b, want %b", got.cell_alive, want.cell_alive));
      if (got.live_total !== want.live_total)
        report_mismatch($sformatf("live_total %0d, want %0d", got.live_total, want.live_total));
      if (got.generation !== want.generation)
        report_mismatch($sformatf("generation %0d, want %0d", got.generation, want.generation));
      if (got.stable !== want.stable)
        report_mismatch($sformatf("stable %b, want %b", got.stable, want.stable));
      if (got.extinct !== want.extinct)
        report_mismatch($sformatf("extinct %b, want %b", got.extinct, want.extinct));
    endtask
  endclass

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           start     = 1'b0;
  logic                           busy;
  lcas_pkg::in_item_t             in_item   = '0;
  logic                           out_strobe;
  lcas_pkg::out_item_t            out_item;
  logic                           cfg_we    = 1'b0;
  logic [lcas_pkg::CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [CFG_W-1:0]               cfg_wdata = '0;

  life_tracker tracker;
  int          sent       = 0;
  int          burst_left = 0;
  int          quiet      = 0;

  life_cellular_automaton_step_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_strobe) tracker.check_result(out_item);
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  function automatic lcas_pkg::in_item_t make_item(lcas_pkg::op_t op, int r, int c);
    lcas_pkg::in_item_t it;
    it.op  = op;
    it.row = 6'(r);
    it.col = 6'(c);
    return it;
  endfunction

  // Mostly a cell inside the area in use, now and then any coordinate at all.
  function automatic lcas_pkg::in_item_t area_item(lcas_pkg::op_t op);
    if ($urandom_range(0, 7) == 0)
      return make_item(op, $urandom_range(0, 63), $urandom_range(0, 63));
    return make_item(op, $urandom_range(0, tracker.eff_rows() - 1),
                     $urandom_range(0, tracker.eff_cols() - 1));
  endfunction

  function automatic logic [CFG_W-1:0] pick_size(bit wide);
    unique case ($urandom_range(0, 9))
      0: return '0;
      1: return CFG_W'(lcas_pkg::MAX_ROWS_DEF);
      2: return CFG_W'($urandom_range(65, 127));
      3: return CFG_W'($urandom_range(1, 3));
      default: return wide ? CFG_W'($urandom_range(1, 64)) : CFG_W'($urandom_range(1, 16));
    endcase
  endfunction

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // A beat is taken at the first rising edge with busy low; the sender then
  // either keeps start high for the next item or pauses.
  task automatic send_item(lcas_pkg::in_item_t it);
    @(negedge clk);
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    tracker.note_item(it);
    sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
      idle_cycles(($urandom_range(0, 4) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 8));
    end
  endtask

  task automatic wait_drain();
    @(negedge clk);
    start <= 1'b0;
    while (tracker.awaited.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [lcas_pkg::CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    tracker.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic directed_checks();
    // The full grid reads dead after reset; a blinker on the top edge and a
    // lone corner cell exercise the borders.
    send_item(make_item(lcas_pkg::OP_READ, 0, 0));
    send_item(make_item(lcas_pkg::OP_SET, 63, 63));
    send_item(make_item(lcas_pkg::OP_SET, 0, 0));
    send_item(make_item(lcas_pkg::OP_SET, 0, 1));
    send_item(make_item(lcas_pkg::OP_SET, 0, 2));
    send_item(make_item(lcas_pkg::OP_SET, 20, 20));
    send_item(make_item(lcas_pkg::OP_READ, 63, 63));
    send_item(make_item(lcas_pkg::OP_ADVANCE, 0, 0));
    send_item(make_item(lcas_pkg::OP_ADVANCE, 63, 63));
    // Zero rows acts as one row and a column count above the bound as 64.
    wait_drain();
    write_reg(lcas_pkg::CFG_ROWS_IDX, '0);
    write_reg(lcas_pkg::CFG_COLS_IDX, '1);
    send_item(make_item(lcas_pkg::OP_SET, 5, 5));
    send_item(make_item(lcas_pkg::OP_READ, 20, 20));
    send_item(make_item(lcas_pkg::OP_SET, 0, 63));
    send_item(make_item(lcas_pkg::OP_ADVANCE, 0, 0));
    wait_drain();
    write_reg(lcas_pkg::CFG_ROWS_IDX, CFG_W'(3));
    write_reg(lcas_pkg::CFG_COLS_IDX, CFG_W'(3));
    send_item(make_item(lcas_pkg::OP_SET, 1, 0));
    send_item(make_item(lcas_pkg::OP_SET, 1, 2));
    send_item(make_item(lcas_pkg::OP_SET, 2, 5));
    send_item(make_item(lcas_pkg::OP_ADVANCE, 0, 0));
    send_item(make_item(lcas_pkg::OP_READ, 0, 1));
    // Growing back must show the cells kept while they were outside the area.
    wait_drain();
    write_reg(lcas_pkg::CFG_ROWS_IDX, CFG_W'(65));
    write_reg(lcas_pkg::CFG_COLS_IDX, CFG_W'(64));
    send_item(make_item(lcas_pkg::OP_READ, 20, 20));
    send_item(make_item(lcas_pkg::OP_SET, 10, 10));
    send_item(make_item(lcas_pkg::OP_SET, 10, 11));
    send_item(make_item(lcas_pkg::OP_SET, 11, 10));
    send_item(make_item(lcas_pkg::OP_SET, 11, 11));
    send_item(make_item(lcas_pkg::OP_ADVANCE, 0, 0));
    send_item(make_item(lcas_pkg::OP_ADVANCE, 0, 0));
    // A set keeps the stable flag; a clear drops it and the generation count.
    send_item(make_item(lcas_pkg::OP_SET, 40, 40));
    send_item(make_item(lcas_pkg::OP_CLEAR, 63, 63));
    send_item(make_item(lcas_pkg::OP_READ, 10, 10));
  endtask

  // One setting of the sizes, a random soup of live cells, then generations
  // with reads in between and a little noise.
  task automatic random_phase();
    int area;
    int seeds;
    int steps;
    int pick;
    wait_drain();
    if ($urandom_range(0, 3) != 0) write_reg(lcas_pkg::CFG_ROWS_IDX, pick_size(1'b0));
    if ($urandom_range(0, 3) != 0) write_reg(lcas_pkg::CFG_COLS_IDX, pick_size(1'b1));
    area = tracker.eff_rows() * tracker.eff_cols();
    if ($urandom_range(0, 2) == 0)
      send_item(make_item(lcas_pkg::OP_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63)));
    seeds = $urandom_range(1, (area < 160) ? area / 4 + 1 : 40);
    for (int i = 0; i < seeds; i++) send_item(area_item(lcas_pkg::OP_SET));
    steps = $urandom_range(5, 30);
    for (int i = 0; i < steps; i++) begin
      pick = $urandom_range(0, 19);
      if (pick < 11) send_item(make_item(lcas_pkg::OP_ADVANCE, $urandom_range(0, 63),
                                         $urandom_range(0, 63)));
      else if (pick < 16) send_item(area_item(lcas_pkg::OP_READ));
      else if (pick < 18) send_item(area_item(lcas_pkg::OP_SET));
      else send_item(make_item(lcas_pkg::op_t'($urandom_range(0, 3)), $urandom_range(0, 63),
                               $urandom_range(0, 63)));
    end
  endtask

  initial begin
    tracker = new;
    tracker.reset_state();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    directed_checks();
    while (sent < ITEM_TARGET) random_phase();
    wait_drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (tracker.errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/lcas_pkg.sv
rtl/life_cellular_automaton_step_unit.sv
rtl/lcas_checker.sv
dv/tb_top.sv
